// ===== hdl/mlgc_pkg.sv =====
// Shared constants, types and command/status structs for the magnetometer
// level-gated calibration unit. No dependencies; imported by every module.

package mlgc_pkg;

  // Field widths
  localparam int SAMPLE_WIDTH    = 16;
  localparam int SCALE_FRAC_BITS = 12;
  localparam int SCALE_WIDTH     = 16;
  localparam int CFG_WIDTH       = 16;
  localparam int LIMIT_WIDTH     = 12;
  localparam int ANGLE_WIDTH     = 13;
  localparam int OP_WIDTH        = 2;
  localparam int CFG_IDX_WIDTH   = 3;

  // Derived datapath widths
  localparam int DIFF_WIDTH   = SAMPLE_WIDTH + 1;
  localparam int PROD_WIDTH   = DIFF_WIDTH + SCALE_WIDTH;
  localparam int RND_WIDTH    = PROD_WIDTH - SCALE_FRAC_BITS;
  localparam int QUO_BITS     = SCALE_WIDTH - 1;
  localparam int QCNT_WIDTH   = $clog2(QUO_BITS);
  localparam int DIV_WIDTH    = SAMPLE_WIDTH + SCALE_WIDTH;

  // Stream widths
  localparam int IN_DATA_WIDTH  = ((3 * SAMPLE_WIDTH + 2 * ANGLE_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_WIDTH = ((3 * SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int OUT_USER_WIDTH = 2;

  typedef logic signed [SAMPLE_WIDTH-1:0] smp_t;
  typedef logic signed [DIFF_WIDTH-1:0]   diff_t;
  typedef logic signed [PROD_WIDTH-1:0]   prod_t;
  typedef logic signed [SCALE_WIDTH-1:0]  scale_t;
  typedef logic signed [CFG_WIDTH-1:0]    cfg_t;
  typedef logic signed [ANGLE_WIDTH-1:0]  angle_t;
  typedef logic signed [ANGLE_WIDTH:0]    angle_ext_t;
  typedef logic        [LIMIT_WIDTH-1:0]  limit_t;

  // Saturation bounds
  localparam smp_t   SMP_MAX   = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam smp_t   SMP_MIN   = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam scale_t SCALE_MAX = {1'b0, {(SCALE_WIDTH-1){1'b1}}};
  localparam scale_t SCALE_MIN = {1'b1, {(SCALE_WIDTH-1){1'b0}}};

  // Unity scale, saturated when the fraction does not fit
  localparam scale_t SCALE_UNITY = (SCALE_FRAC_BITS >= SCALE_WIDTH - 1) ? SCALE_MAX :
                                   scale_t'(64'sd1 << SCALE_FRAC_BITS);
  localparam prod_t  ROUND_HALF  = prod_t'(64'sd1 << (SCALE_FRAC_BITS - 1));

  // Register reset values
  localparam cfg_t   RST_X_MIN = cfg_t'(-456);
  localparam cfg_t   RST_X_MAX = cfg_t'(154);
  localparam cfg_t   RST_Y_MIN = cfg_t'(-58);
  localparam cfg_t   RST_Y_MAX = cfg_t'(518);
  localparam cfg_t   RST_Z_MIN = cfg_t'(523);
  localparam cfg_t   RST_Z_MAX = cfg_t'(907);
  localparam limit_t RST_LIMIT = limit_t'(32);

  // Operation codes carried in in_tuser
  typedef enum logic [OP_WIDTH-1:0] {
    OP_SAMPLE = 2'd0,
    OP_COMMIT = 2'd1,
    OP_LOAD   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_X_MIN       = 3'd0,
    CFG_X_MAX       = 3'd1,
    CFG_Y_MIN       = 3'd2,
    CFG_Y_MAX       = 3'd3,
    CFG_Z_MIN       = 3'd4,
    CFG_Z_MAX       = 3'd5,
    CFG_LEVEL_LIMIT = 3'd6
  } cfg_idx_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic mul_y;
    logic mul_z;
    logic fin_sample;
    logic derive;
    logic div_y_start;
    logic div_z_start;
    logic load_out;
  } mlgc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t  in_op;
    logic div_done;
    logic out_free;
  } mlgc_sts_t;

endpackage

// ===== hdl/mlgc_div.sv =====
// Iterative scale divider: (num << SCALE_FRAC_BITS) / den, one quotient bit
// per cycle, with saturation and fault detection. Depends on mlgc_pkg.

module mlgc_div
  import mlgc_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  input  diff_t  num,
  input  diff_t  den,
  output logic   done,
  output scale_t quotient,
  output logic   fault
);

  logic                  busy_r;
  logic                  done_r;
  logic [QCNT_WIDTH-1:0] cnt_r;
  logic [DIV_WIDTH-1:0]  rem_r;
  logic [DIV_WIDTH-1:0]  dsh_r;
  logic [QUO_BITS-1:0]   quo_r;
  logic                  neg_r;
  logic                  fault_r;
  scale_t                res_r;

  diff_t                 num_neg;
  logic [SAMPLE_WIDTH-1:0] num_mag;
  logic [DIV_WIDTH-1:0]  num_full;
  logic [DIV_WIDTH-1:0]  den_full;
  logic                  den_bad;
  logic                  ovf;
  logic                  step_ge;
  logic [QUO_BITS-1:0]   quo_nxt;
  scale_t                quo_pos;

  // Operand setup: magnitude of numerator, divisor aligned to top quotient bit
  always_comb begin
    num_neg  = -num;
    num_mag  = num[DIFF_WIDTH-1] ? num_neg[SAMPLE_WIDTH-1:0] : num[SAMPLE_WIDTH-1:0];
    num_full = DIV_WIDTH'(num_mag) << SCALE_FRAC_BITS;
    den_full = DIV_WIDTH'(den[SAMPLE_WIDTH-1:0]) << QUO_BITS;
    den_bad  = den[DIFF_WIDTH-1] || (den == '0);
    ovf      = (num_full >= den_full);
  end

  // One restoring step
  always_comb begin
    step_ge = (rem_r >= dsh_r);
    quo_nxt = {quo_r[QUO_BITS-2:0], step_ge};
    quo_pos = scale_t'({1'b0, quo_nxt});
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (den_bad || ovf) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= QCNT_WIDTH'(QUO_BITS - 1);
        end
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[DIFF_WIDTH-1];
      rem_r <= num_full;
      dsh_r <= den_full >> 1;
      quo_r <= '0;
      if (den_bad) begin
        res_r   <= SCALE_MAX;
        fault_r <= 1'b1;
      end else if (ovf) begin
        res_r   <= num[DIFF_WIDTH-1] ? SCALE_MIN : SCALE_MAX;
        fault_r <= num[DIFF_WIDTH-1];
      end else begin
        fault_r <= num[DIFF_WIDTH-1] || (num == '0);
      end
    end else if (busy_r) begin
      if (step_ge) begin
        rem_r <= rem_r - dsh_r;
      end
      dsh_r <= dsh_r >> 1;
      quo_r <= quo_nxt;
      if (cnt_r == '0) begin
        res_r <= neg_r ? -quo_pos : quo_pos;
      end
    end
  end

  assign done     = done_r;
  assign quotient = res_r;
  assign fault    = fault_r;

  // A new division is only started on an idle unit
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (!busy_r && !done_r))
    else $error("divider started while busy");

  // Completion never overlaps an iteration
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider done while still iterating");

endmodule

// ===== hdl/mlgc_datapath.sv =====
// Datapath: configuration registers, calibration state, shared multiplier,
// scale divider and output register. Depends on mlgc_pkg and mlgc_div.

module mlgc_datapath
  import mlgc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  // Input stream payload
  input  logic [IN_DATA_WIDTH-1:0]  in_tdata,
  input  logic [OP_WIDTH-1:0]       in_tuser,
  // Output stream
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [OUT_DATA_WIDTH-1:0] out_tdata,
  output logic [OUT_USER_WIDTH-1:0] out_tuser,
  // Configuration writes
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
  input  logic [CFG_WIDTH-1:0]      cfg_data,
  // Controller link
  input  mlgc_cmd_t                 cmd,
  output mlgc_sts_t                 sts
);

  // Configuration
  cfg_t   def_min_r [3];
  cfg_t   def_max_r [3];
  limit_t lim_r;

  // Calibration state
  smp_t   track_min_r [3];
  smp_t   track_max_r [3];
  logic   track_valid_r;
  smp_t   off_r [3];
  scale_t ys_r;
  scale_t zs_r;

  // Working registers
  smp_t   raw_r [3];
  angle_t pitch_r;
  angle_t roll_r;
  op_t    op_r;
  prod_t  prod_r;
  smp_t   adj_r [3];
  logic   tracked_r;
  logic   fault_r;
  diff_t  xr_r;
  diff_t  ry_r;
  diff_t  rz_r;
  logic   div_sel_r;

  // Output register
  logic                      out_valid_r;
  logic [OUT_DATA_WIDTH-1:0] out_data_r;
  logic [OUT_USER_WIDTH-1:0] out_user_r;
  logic [OUT_DATA_WIDTH-1:0] out_data_nxt;

  // Combinational
  diff_t      diff_x;
  diff_t      diff_y;
  diff_t      diff_z;
  diff_t      mul_a;
  scale_t     mul_b;
  prod_t      mul_p;
  smp_t       rnd_res;
  smp_t       sel_min [3];
  smp_t       sel_max [3];
  diff_t      mid_sum [3];
  smp_t       off_nxt [3];
  angle_ext_t p_ext;
  angle_ext_t r_ext;
  angle_ext_t l_ext;
  logic       level;
  logic       div_start;
  diff_t      div_den;
  logic       div_done;
  scale_t     div_quo;
  logic       div_fault;

  // Saturate a one-bit-wider difference to the sample width
  function automatic smp_t sat_diff(diff_t d);
    smp_t r;
    if (d[DIFF_WIDTH-1] != d[DIFF_WIDTH-2]) begin
      r = d[DIFF_WIDTH-1] ? SMP_MIN : SMP_MAX;
    end else begin
      r = d[SAMPLE_WIDTH-1:0];
    end
    return r;
  endfunction

  // Round half up, drop fraction bits, saturate
  function automatic smp_t round_sat(prod_t p);
    prod_t                           t;
    logic signed [RND_WIDTH-1:0]     s;
    logic [RND_WIDTH-SAMPLE_WIDTH:0] top;
    smp_t                            r;
    t   = p + ROUND_HALF;
    s   = t[PROD_WIDTH-1:SCALE_FRAC_BITS];
    top = s[RND_WIDTH-1:SAMPLE_WIDTH-1];
    if ((&top) || !(|top)) begin
      r = s[SAMPLE_WIDTH-1:0];
    end else begin
      r = s[RND_WIDTH-1] ? SMP_MIN : SMP_MAX;
    end
    return r;
  endfunction

  // Offset-corrected samples and the shared multiplier
  always_comb begin
    diff_x  = diff_t'(raw_r[0]) - diff_t'(off_r[0]);
    diff_y  = diff_t'(raw_r[1]) - diff_t'(off_r[1]);
    diff_z  = diff_t'(raw_r[2]) - diff_t'(off_r[2]);
    mul_a   = cmd.mul_z ? diff_z : diff_y;
    mul_b   = cmd.mul_z ? zs_r : ys_r;
    mul_p   = prod_t'(mul_a) * prod_t'(mul_b);
    rnd_res = round_sat(prod_r);
  end

  // Level gate on pitch and roll
  always_comb begin
    p_ext = angle_ext_t'(pitch_r);
    r_ext = angle_ext_t'(roll_r);
    l_ext = angle_ext_t'({1'b0, lim_r});
    level = (p_ext <= l_ext) && (-p_ext <= l_ext) &&
            (r_ext <= l_ext) && (-r_ext <= l_ext);
  end

  // Extremes source for commit or load, and midpoints
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (op_r == OP_COMMIT) begin
        sel_min[i] = track_min_r[i];
        sel_max[i] = track_max_r[i];
      end else begin
        sel_min[i] = smp_t'(def_min_r[i]);
        sel_max[i] = smp_t'(def_max_r[i]);
      end
      mid_sum[i] = diff_t'(sel_max[i]) + diff_t'(sel_min[i]);
      off_nxt[i] = mid_sum[i][SAMPLE_WIDTH:1];
    end
  end

  // Configuration register writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      def_min_r[0] <= RST_X_MIN;
      def_max_r[0] <= RST_X_MAX;
      def_min_r[1] <= RST_Y_MIN;
      def_max_r[1] <= RST_Y_MAX;
      def_min_r[2] <= RST_Z_MIN;
      def_max_r[2] <= RST_Z_MAX;
      lim_r        <= RST_LIMIT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_X_MIN:       def_min_r[0] <= cfg_t'(cfg_data);
        CFG_X_MAX:       def_max_r[0] <= cfg_t'(cfg_data);
        CFG_Y_MIN:       def_min_r[1] <= cfg_t'(cfg_data);
        CFG_Y_MAX:       def_max_r[1] <= cfg_t'(cfg_data);
        CFG_Z_MIN:       def_min_r[2] <= cfg_t'(cfg_data);
        CFG_Z_MAX:       def_max_r[2] <= cfg_t'(cfg_data);
        CFG_LEVEL_LIMIT: lim_r        <= cfg_data[LIMIT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Calibration state: tracked extremes, offsets, scales
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        track_min_r[i] <= '0;
        track_max_r[i] <= '0;
        off_r[i]       <= '0;
      end
      track_valid_r <= 1'b0;
      ys_r          <= SCALE_UNITY;
      zs_r          <= SCALE_UNITY;
    end else begin
      if (cmd.fin_sample && level) begin
        for (int i = 0; i < 3; i++) begin
          if (!track_valid_r) begin
            track_min_r[i] <= raw_r[i];
            track_max_r[i] <= raw_r[i];
          end else begin
            if (raw_r[i] > track_max_r[i]) begin
              track_max_r[i] <= raw_r[i];
            end
            if (raw_r[i] < track_min_r[i]) begin
              track_min_r[i] <= raw_r[i];
            end
          end
        end
        track_valid_r <= 1'b1;
      end
      if (cmd.derive) begin
        for (int i = 0; i < 3; i++) begin
          off_r[i] <= off_nxt[i];
        end
      end
      if (div_done) begin
        if (div_sel_r) begin
          zs_r <= div_quo;
        end else begin
          ys_r <= div_quo;
        end
      end
    end
  end

  // Item working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      raw_r[0]  <= in_tdata[SAMPLE_WIDTH-1:0];
      raw_r[1]  <= in_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
      raw_r[2]  <= in_tdata[3*SAMPLE_WIDTH-1:2*SAMPLE_WIDTH];
      pitch_r   <= in_tdata[3*SAMPLE_WIDTH+ANGLE_WIDTH-1:3*SAMPLE_WIDTH];
      roll_r    <= in_tdata[3*SAMPLE_WIDTH+2*ANGLE_WIDTH-1:3*SAMPLE_WIDTH+ANGLE_WIDTH];
      op_r      <= op_t'(in_tuser);
      adj_r[0]  <= '0;
      adj_r[1]  <= '0;
      adj_r[2]  <= '0;
      tracked_r <= 1'b0;
      fault_r   <= 1'b0;
    end
    if (cmd.mul_y || cmd.mul_z) begin
      prod_r <= mul_p;
    end
    if (cmd.mul_y) begin
      adj_r[0] <= sat_diff(diff_x);
    end
    if (cmd.mul_z) begin
      adj_r[1] <= rnd_res;
    end
    if (cmd.fin_sample) begin
      adj_r[2]  <= rnd_res;
      tracked_r <= level;
    end
    if (cmd.derive) begin
      xr_r <= diff_t'(sel_max[0]) - diff_t'(sel_min[0]);
      ry_r <= diff_t'(sel_max[1]) - diff_t'(sel_min[1]);
      rz_r <= diff_t'(sel_max[2]) - diff_t'(sel_min[2]);
    end
    if (cmd.div_y_start) begin
      div_sel_r <= 1'b0;
    end
    if (cmd.div_z_start) begin
      div_sel_r <= 1'b1;
    end
    if (div_done && div_fault) begin
      fault_r <= 1'b1;
    end
  end

  // Shared scale divider
  assign div_start = cmd.div_y_start || cmd.div_z_start;
  assign div_den   = cmd.div_z_start ? rz_r : ry_r;

  mlgc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .num      (xr_r),
    .den      (div_den),
    .done     (div_done),
    .quotient (div_quo),
    .fault    (div_fault)
  );

  // Output register: holds a result while the next item is taken in
  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[SAMPLE_WIDTH-1:0]              = adj_r[0];
    out_data_nxt[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH] = adj_r[1];
    out_data_nxt[3*SAMPLE_WIDTH-1:2*SAMPLE_WIDTH] = adj_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= out_data_nxt;
      out_user_r <= {fault_r, tracked_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // Status to controller
  assign sts.in_op    = op_t'(in_tuser);
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_tready;

  // A result is only loaded into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_tready))
    else $error("output register overwritten");

  // Sample flag and range fault come from different operations
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_user_r[0] && out_user_r[1]))
    else $error("tracked and range_fault both set");

  // Once seeded, the tracked extremes stay seeded
  a_track_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    track_valid_r |=> track_valid_r)
    else $error("track valid dropped");

  // Tracked extremes stay ordered
  a_track_order: assert property (@(posedge clk) disable iff (!rst_n)
    track_valid_r |-> (track_min_r[0] <= track_max_r[0] &&
                       track_min_r[1] <= track_max_r[1] &&
                       track_min_r[2] <= track_max_r[2]))
    else $error("tracked min above max");

endmodule

// ===== hdl/mlgc_ctrl.sv =====
// Controller state machine: sequences sample correction, commit/load
// derivation and result hand-off. Depends on mlgc_pkg.

module mlgc_ctrl
  import mlgc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  mlgc_sts_t sts,
  output mlgc_cmd_t cmd
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_MUL_Y  = 11'b000_0000_0010,
    S_MUL_Z  = 11'b000_0000_0100,
    S_FIN    = 11'b000_0000_1000,
    S_DERIVE = 11'b000_0001_0000,
    S_DIV_Y  = 11'b000_0010_0000,
    S_WAIT_Y = 11'b000_0100_0000,
    S_DIV_Z  = 11'b000_1000_0000,
    S_WAIT_Z = 11'b001_0000_0000,
    S_DONE   = 11'b010_0000_0000,
    S_SPARE  = 11'b100_0000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          unique case (sts.in_op)
            OP_SAMPLE:         state_nxt = S_MUL_Y;
            OP_COMMIT,
            OP_LOAD:           state_nxt = S_DERIVE;
            default:           state_nxt = S_DONE;
          endcase
        end
      end
      S_MUL_Y:  state_nxt = S_MUL_Z;
      S_MUL_Z:  state_nxt = S_FIN;
      S_FIN:    state_nxt = S_DONE;
      S_DERIVE: state_nxt = S_DIV_Y;
      S_DIV_Y:  state_nxt = S_WAIT_Y;
      S_WAIT_Y: begin
        if (sts.div_done) begin
          state_nxt = S_DIV_Z;
        end
      end
      S_DIV_Z:  state_nxt = S_WAIT_Z;
      S_WAIT_Z: begin
        if (sts.div_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Commands to the datapath
  assign in_tready       = (state_r == S_IDLE);
  assign cmd.capture     = (state_r == S_IDLE) && in_tvalid;
  assign cmd.mul_y       = (state_r == S_MUL_Y);
  assign cmd.mul_z       = (state_r == S_MUL_Z);
  assign cmd.fin_sample  = (state_r == S_FIN);
  assign cmd.derive      = (state_r == S_DERIVE);
  assign cmd.div_y_start = (state_r == S_DIV_Y);
  assign cmd.div_z_start = (state_r == S_DIV_Z);
  assign cmd.load_out    = (state_r == S_DONE) && sts.out_free;

endmodule

// ===== hdl/magnetometer_level_gated_calibration_unit.sv =====
// Top level of the magnetometer level-gated calibration unit.
// Depends on mlgc_pkg, mlgc_ctrl, mlgc_datapath (and mlgc_div below it).

// One item is worked on at a time. in_tready is high only while the
// controller is idle. A finished result waits in the output register, so the
// next item can be taken before the result is read. A sample passes through
// the multiply-y, multiply-z and finish states and its result is loaded in
// the done state, after which the controller returns to idle. Samples use one
// shared 17x16 multiplier, first for y and then for z. The shared divider
// sets the time for commit and load. It produces one quotient bit per cycle
// for each of the two scales (15 steps each). A zero, negative or saturating
// range finishes that division without any quotient steps. For operation
// code 3 the controller goes straight to the done state. While an earlier
// result is held by out_tready low, the hand-off waits in the done state.
// There is no clearing pass after reset. Configuration writes are always
// taken (cfg_ready is high) and must only be issued while the block is idle.

module magnetometer_level_gated_calibration_unit
  import mlgc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  // Input stream
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // tdata, low bit up: mag_x[15:0], mag_y[31:16], mag_z[47:32],
  // pitch[60:48], roll[73:61], zero pad [79:74]
  input  logic [IN_DATA_WIDTH-1:0]  in_tdata,
  // tuser: operation[1:0]
  input  logic [OP_WIDTH-1:0]       in_tuser,
  // Result stream
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // tdata, low bit up: adj_x[15:0], adj_y[31:16], adj_z[47:32]
  output logic [OUT_DATA_WIDTH-1:0] out_tdata,
  // tuser, low bit up: tracked[0], range_fault[1]
  output logic [OUT_USER_WIDTH-1:0] out_tuser,
  // Configuration write channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
  input  logic [CFG_WIDTH-1:0]      cfg_data
);

  mlgc_cmd_t cmd;
  mlgc_sts_t sts;

  mlgc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mlgc_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

// ===== bench/magnetometer_level_gated_calibration_unit_tb.sv =====
// Self-checking testbench for magnetometer_level_gated_calibration_unit.
// Holds a cycle-free predictor of the correction and calibration state.
// Depends on mlgc_pkg and the unit's RTL only.
`timescale 1ns / 1ps

module magnetometer_level_gated_calibration_unit_tb;
  import mlgc_pkg::*;

  typedef longint axis3_t [3];

  // One expected result transaction
  typedef struct packed {
    smp_t adj_x;
    smp_t adj_y;
    smp_t adj_z;
    logic tracked;
    logic fault;
  } cal_result_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_tvalid;
  logic                      in_tready;
  logic [IN_DATA_WIDTH-1:0]  in_tdata;
  logic [OP_WIDTH-1:0]       in_tuser;
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [OUT_DATA_WIDTH-1:0] out_tdata;
  logic [OUT_USER_WIDTH-1:0] out_tuser;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IDX_WIDTH-1:0]  cfg_index;
  logic [CFG_WIDTH-1:0]      cfg_data;

  magnetometer_level_gated_calibration_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Predictor state: tracked extremes, derived corrections, registers
  axis3_t trk_min = '{0, 0, 0};
  axis3_t trk_max = '{0, 0, 0};
  bit     trk_seen = 0;
  axis3_t offs = '{0, 0, 0};
  longint scl_y = SCALE_UNITY;
  longint scl_z = SCALE_UNITY;
  longint dflt [6] = '{RST_X_MIN, RST_X_MAX, RST_Y_MIN, RST_Y_MAX, RST_Z_MIN, RST_Z_MAX};
  longint lvl_lim = RST_LIMIT;

  cal_result_t cal_expect_q [$];
  cal_result_t want_res;
  cal_result_t got_res;

  // Run statistics
  int err_cnt = 0;
  int n_results = 0;
  int n_samples = 0;
  int n_tracked = 0;
  int n_commits = 0;
  int n_loads = 0;
  int n_unused = 0;
  int n_cfg_writes = 0;

  bit calm;          // no idling on either side while set
  int rdy_hold = 0;

  // Clock, 10 ns period
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint sat_to(longint v, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  // Q4.12 ratio of x range over an axis range
  function automatic longint scale_for(longint xr, longint rng, inout bit fault);
    if (rng <= 0) begin
      fault = 1'b1;
      return SCALE_MAX;
    end
    if (xr <= 0)
      fault = 1'b1;
    return sat_to((xr <<< SCALE_FRAC_BITS) / rng, SCALE_WIDTH);
  endfunction

  // Midpoint offsets and y/z scales from a set of extremes
  function automatic bit derive_cal(axis3_t lo, axis3_t hi);
    bit     fault;
    longint xr;
    fault = 1'b0;
    xr = hi[0] - lo[0];
    for (int i = 0; i < 3; i++)
      offs[i] = (hi[i] + lo[i]) >>> 1;
    scl_y = scale_for(xr, hi[1] - lo[1], fault);
    scl_z = scale_for(xr, hi[2] - lo[2], fault);
    return fault;
  endfunction

  function automatic cal_result_t predict_correction(op_t op, smp_t mx, smp_t my, smp_t mz,
                                                     angle_t p, angle_t r);
    cal_result_t res;
    axis3_t      raw;
    axis3_t      lo;
    axis3_t      hi;
    longint      pv;
    longint      rv;
    longint      rnd;
    res = '0;
    raw[0] = mx;
    raw[1] = my;
    raw[2] = mz;
    pv = p;
    rv = r;
    rnd = longint'(1) <<< (SCALE_FRAC_BITS - 1);
    case (op)
      OP_SAMPLE: begin
        res.adj_x = smp_t'(sat_to(raw[0] - offs[0], SAMPLE_WIDTH));
        res.adj_y = smp_t'(sat_to(((raw[1] - offs[1]) * scl_y + rnd) >>> SCALE_FRAC_BITS,
                                  SAMPLE_WIDTH));
        res.adj_z = smp_t'(sat_to(((raw[2] - offs[2]) * scl_z + rnd) >>> SCALE_FRAC_BITS,
                                  SAMPLE_WIDTH));
        // level gate on both angles
        if (pv <= lvl_lim && -pv <= lvl_lim && rv <= lvl_lim && -rv <= lvl_lim) begin
          res.tracked = 1'b1;
          for (int i = 0; i < 3; i++) begin
            if (!trk_seen) begin
              trk_min[i] = raw[i];
              trk_max[i] = raw[i];
            end else begin
              if (raw[i] > trk_max[i]) trk_max[i] = raw[i];
              if (raw[i] < trk_min[i]) trk_min[i] = raw[i];
            end
          end
          trk_seen = 1'b1;
        end
      end
      OP_COMMIT: begin
        res.fault = derive_cal(trk_min, trk_max);
      end
      OP_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          lo[i] = dflt[2 * i];
          hi[i] = dflt[2 * i + 1];
        end
        res.fault = derive_cal(lo, hi);
      end
      default: ;
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------- handshakes

  // Idle length: mostly none or short, now and then long
  function automatic int draw_gap();
    int w;
    w = $urandom_range(0, 99);
    if (w < 55) return 0;
    if (w < 85) return $urandom_range(1, 3);
    if (w < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Send one input transaction and record its expected result
  task automatic send_item(op_t op, smp_t mx, smp_t my, smp_t mz, angle_t p, angle_t r);
    int gap;
    cal_result_t res;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_DATA_WIDTH'({r, p, mz, my, mx});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    res = predict_correction(op, mx, my, mz, p, r);
    cal_expect_q.push_back(res);
    case (op)
      OP_SAMPLE: begin
        n_samples++;
        if (res.tracked) n_tracked++;
      end
      OP_COMMIT: n_commits++;
      OP_LOAD:   n_loads++;
      default:   n_unused++;
    endcase
    gap = calm ? 0 : draw_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Let every outstanding result drain so the unit is idle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (cal_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [CFG_WIDTH-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_LEVEL_LIMIT)
      lvl_lim = longint'(val[LIMIT_WIDTH-1:0]);
    else
      dflt[idx] = longint'(cfg_t'(val));
    n_cfg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(logic [CFG_WIDTH-1:0] xmn, logic [CFG_WIDTH-1:0] xmx,
                           logic [CFG_WIDTH-1:0] ymn, logic [CFG_WIDTH-1:0] ymx,
                           logic [CFG_WIDTH-1:0] zmn, logic [CFG_WIDTH-1:0] zmx,
                           logic [CFG_WIDTH-1:0] lim);
    cfg_write(CFG_X_MIN, xmn);
    cfg_write(CFG_X_MAX, xmx);
    cfg_write(CFG_Y_MIN, ymn);
    cfg_write(CFG_Y_MAX, ymx);
    cfg_write(CFG_Z_MIN, zmn);
    cfg_write(CFG_Z_MAX, zmx);
    cfg_write(CFG_LEVEL_LIMIT, lim);
  endtask

  // Result side back-pressure
  always @(posedge clk) begin
    if (rdy_hold > 0) begin
      out_tready <= 1'b0;
      rdy_hold   <= rdy_hold - 1;
    end else begin
      out_tready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0)
        rdy_hold <= draw_gap();
    end
  end

  // ---------------------------------------------------------------- checker

  function automatic void check_field(string what, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%h, actual 0x%h", $time, what, want, got);
      err_cnt++;
    end
  endfunction

  // Compare each result transaction against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      got_res = {out_tdata[15:0], out_tdata[31:16], out_tdata[47:32], out_tuser[0],
                 out_tuser[1]};
      if (cal_expect_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual 0x%h", $time, got_res);
        err_cnt++;
      end else begin
        want_res = cal_expect_q.pop_front();
        check_field("adj_x", want_res.adj_x, got_res.adj_x);
        check_field("adj_y", want_res.adj_y, got_res.adj_y);
        check_field("adj_z", want_res.adj_z, got_res.adj_z);
        check_field("tracked", 16'(want_res.tracked), 16'(got_res.tracked));
        check_field("range_fault", 16'(want_res.fault), 16'(got_res.fault));
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // Power-up state, gate edges, saturation, commit before any level sample
  task automatic test_power_up();
    calm <= 1'b1;
    send_item(OP_SAMPLE, 100, -200, 300, 40, 0);
    send_item(OP_COMMIT, 0, 0, 0, 0, 0);
    send_item(OP_NONE, -1, -1, -1, -1, -1);
    send_item(OP_LOAD, 0, 0, 0, 0, 0);
    send_item(OP_SAMPLE, 32767, -32768, -32768, 32, -32);
    send_item(OP_SAMPLE, -32768, 32767, 32767, -32, 32);
    send_item(OP_SAMPLE, 5, 6, 7, 33, 0);
    send_item(OP_SAMPLE, 5, 6, 7, 0, -33);
    send_item(OP_SAMPLE, 5, 6, 7, -4096, 4095);
    send_item(OP_COMMIT, 0, 0, 0, 0, 0);
    send_item(OP_SAMPLE, 0, 0, 0, 0, 0);
    send_item(OP_SAMPLE, -1, 1, -1, 2880, -2880);
  endtask

  // Register extremes: full x span, unit and zero and negative ranges, gate limits
  task automatic test_register_extremes();
    wait_idle();
    calm <= 1'b0;
    write_all(16'h8000, 16'h7FFF, 16'd0, 16'd1, 16'd5, 16'd5, 16'd0);
    send_item(OP_LOAD, 0, 0, 0, 0, 0);
    send_item(OP_SAMPLE, 1000, -3, 7, 0, 0);
    send_item(OP_SAMPLE, 1000, -3, 7, 1, 0);
    wait_idle();
    write_all(16'd100, -16'sd100, -16'sd10, 16'd10, 16'h7FFF, 16'h8000, 16'hFFFF);
    send_item(OP_LOAD, 0, 0, 0, 0, 0);
    send_item(OP_SAMPLE, 12345, -9, 9, 4095, -4095);
    send_item(OP_SAMPLE, 12345, -9, 9, -4096, 0);
    wait_idle();
    write_all(16'd0, 16'd0, 16'd1, 16'd2, -16'sd5, 16'd5, 16'd2880);
    send_item(OP_LOAD, 0, 0, 0, 0, 0);
    send_item(OP_SAMPLE, -7, 3, -3, 2880, 2880);
  endtask

  // Well-formed calibration traffic with random content, some noise
  task automatic test_random_phases();
    int     ctr [3];
    int     amp [3];
    int     dc;
    int     da;
    int     lim;
    int     w;
    longint v;
    smp_t   mag [3];
    angle_t p;
    angle_t r;
    logic [CFG_WIDTH-1:0] cv [6];
    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      calm <= (ph % 3 == 1);
      // defaults around a center, sometimes fully random
      for (int a = 0; a < 3; a++) begin
        dc = int'($urandom_range(0, 24000)) - 12000;
        da = $urandom_range(1, 6000);
        cv[2 * a]     = CFG_WIDTH'(dc - da);
        cv[2 * a + 1] = CFG_WIDTH'(dc + da);
        if ($urandom_range(0, 7) == 0) cv[2 * a]     = CFG_WIDTH'($urandom);
        if ($urandom_range(0, 7) == 0) cv[2 * a + 1] = CFG_WIDTH'($urandom);
      end
      lim = ($urandom_range(0, 5) == 0) ? $urandom_range(2881, 4095) : $urandom_range(0, 2880);
      write_all(cv[0], cv[1], cv[2], cv[3], cv[4], cv[5],
                {4'($urandom), LIMIT_WIDTH'(lim)});
      for (int a = 0; a < 3; a++) begin
        ctr[a] = int'($urandom_range(0, 24000)) - 12000;
        amp[a] = $urandom_range(1, 8000);
      end
      for (int k = 0; k < 212; k++) begin
        // sender holds off until the unit has drained
        if (k == 100) wait_idle();
        for (int a = 0; a < 3; a++) begin
          v = ctr[a] + int'($urandom_range(0, 2 * amp[a])) - amp[a];
          mag[a] = smp_t'(sat_to(v, SAMPLE_WIDTH));
          if ($urandom_range(0, 6) == 0) mag[a] = smp_t'($urandom);
        end
        w = $urandom_range(0, 99);
        if (w < 70) begin
          p = angle_t'(int'($urandom_range(0, 2 * lvl_lim)) - lvl_lim);
          r = angle_t'(int'($urandom_range(0, 2 * lvl_lim)) - lvl_lim);
        end else if (w < 90) begin
          p = angle_t'(int'($urandom_range(0, 5760)) - 2880);
          r = angle_t'(int'($urandom_range(0, 5760)) - 2880);
        end else begin
          p = angle_t'($urandom);
          r = angle_t'($urandom);
        end
        w = $urandom_range(0, 99);
        if (w < 78)
          send_item(OP_SAMPLE, mag[0], mag[1], mag[2], p, r);
        else if (w < 88)
          send_item(OP_COMMIT, mag[0], mag[1], mag[2], p, r);
        else if (w < 95)
          send_item(OP_LOAD, mag[0], mag[1], mag[2], p, r);
        else
          send_item(OP_NONE, mag[0], mag[1], mag[2], p, r);
      end
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= OP_SAMPLE;
    cfg_valid  <= 1'b0;
    cfg_index  <= CFG_X_MIN;
    cfg_data   <= '0;
    calm       <= 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_power_up();
    test_register_extremes();
    test_random_phases();

    // drain, then allow for the longest derive latency
    wait_idle();
    repeat (50) @(posedge clk);

    $display("Covered %0d samples (%0d level-tracked), %0d commits, %0d loads, %0d unused codes",
             n_samples, n_tracked, n_commits, n_loads, n_unused);
    $display("with %0d register writes; %0d results checked, %0d mismatches",
             n_cfg_writes, n_results, err_cnt);
    if (err_cnt == 0 && cal_expect_q.size() == 0)
      $display("magnetometer_level_gated_calibration_unit regression: pass");
    else
      $display("magnetometer_level_gated_calibration_unit regression: fail");
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("Timeout with %0d results outstanding", cal_expect_q.size());
    $display("magnetometer_level_gated_calibration_unit regression: fail");
    $finish;
  end

endmodule
